// ===== src/ofs_pkg.sv =====
// Shared constants for the overlapping frame splitter.
// Used by every module under src; has no dependencies of its own.
package ofs_pkg;

  // Configuration register width and indexes.
  localparam int CFG_BITS       = 7;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HOP          = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ROUND_POW2   = 2'd2;

  localparam logic [CFG_BITS-1:0] FRAME_LENGTH_RESET = 7'd32;
  localparam logic [CFG_BITS-1:0] HOP_RESET          = 7'd16;
  localparam logic                ROUND_POW2_RESET   = 1'b0;

  // Input command codes carried on tuser.
  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Width of the position field in each result.
  localparam int POS_BITS = 6;

  // Frame descriptor queue between the front and back parts.
  localparam int QUEUE_DEPTH    = 2;
  localparam int QUEUE_PTR_BITS = 1;
  localparam int QUEUE_CNT_BITS = 2;

endpackage

// ===== src/ofs_front.sv =====
// Front part of the overlapping frame splitter: accepts samples and flushes,
// writes the sample store and queues one descriptor per frame to emit.
// Depends on ofs_pkg.
module ofs_front #(
  parameter int MAX_FRAME   = 64,
  parameter int SAMPLE_BITS = 16,
  parameter int CW          = $clog2(MAX_FRAME + 1),
  parameter int AW          = $clog2(MAX_FRAME) + 1,
  parameter int PW          = AW + 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_cmd,
  input  logic [SAMPLE_BITS-1:0]       in_sample,
  input  logic [ofs_pkg::CFG_BITS-1:0] len_cfg,
  input  logic [ofs_pkg::CFG_BITS-1:0] hop_cfg,
  input  logic                         pow2_cfg,
  input  logic                         pend_valid,
  input  logic [PW-1:0]                pend_start,
  input  logic                         q_full,
  output logic                         q_push,
  output logic [PW+2*CW-1:0]           q_data,
  output logic                         wr_en,
  output logic [AW-1:0]                wr_addr,
  output logic [SAMPLE_BITS-1:0]       wr_data
);

  localparam int LW = (CW > ofs_pkg::CFG_BITS) ? CW : ofs_pkg::CFG_BITS;

  function automatic logic [CW-1:0] clamp_len(input logic [ofs_pkg::CFG_BITS-1:0] v);
    logic [LW-1:0] x;
    x = LW'(v);
    if (x == '0) x = LW'(1);
    if (x > LW'(MAX_FRAME)) x = LW'(MAX_FRAME);
    return CW'(x);
  endfunction

  function automatic logic [CW-1:0] pad_len(input logic [CW-1:0] l, input logic en);
    logic [CW:0] p;
    p = {1'b0, l};
    for (int k = CW; k >= 0; k--) begin
      if (((CW+1)'(1) << k) >= {1'b0, l}) p = (CW+1)'(1) << k;
    end
    if (p > (CW+1)'(MAX_FRAME)) p = (CW+1)'(MAX_FRAME);
    return en ? CW'(p) : l;
  endfunction

  logic [CW-1:0] fill, fill_next;
  logic [PW-1:0] rs, rs_next;
  logic [CW-1:0] skip, skip_next;

  logic [CW-1:0] eff_len, eff_hop, pad;
  logic [CW-1:0] fill_inc;
  logic          has_room;
  logic [PW-1:0] wp, lag;
  logic          hazard, accept;
  logic [PW-1:0] d_start;
  logic [CW-1:0] d_take, d_total;

  assign eff_len  = clamp_len(len_cfg);
  assign eff_hop  = clamp_len(hop_cfg);
  assign pad      = pad_len(eff_len, pow2_cfg);
  assign has_room = fill < CW'(MAX_FRAME);
  assign fill_inc = has_room ? fill + CW'(1) : fill;
  assign wp       = rs + PW'(fill);
  assign lag      = wp - pend_start;
  // Stop before the write pointer laps the oldest frame still being read.
  assign hazard   = pend_valid && lag[AW];
  assign in_ready = !q_full && !hazard;
  assign accept   = in_valid && in_ready;

  assign wr_addr = wp[AW-1:0];
  assign wr_data = in_sample;
  assign q_data  = {d_total, d_take, d_start};

  always_comb begin
    fill_next = fill;
    rs_next   = rs;
    skip_next = skip;
    q_push    = 1'b0;
    wr_en     = 1'b0;
    d_start   = rs;
    d_take    = eff_len;
    d_total   = pad;
    if (accept) begin
      if (in_cmd == ofs_pkg::CMD_FLUSH) begin
        if (fill != '0) begin
          q_push    = 1'b1;
          d_take    = (fill > pad) ? pad : fill;
          fill_next = '0;
          rs_next   = wp;
        end
      end else if (skip != '0) begin
        skip_next = skip - CW'(1);
      end else begin
        wr_en = has_room;
        if (fill_inc >= eff_len) begin
          q_push = 1'b1;
          if (eff_hop < fill_inc) begin
            rs_next   = rs + PW'(eff_hop);
            fill_next = fill_inc - eff_hop;
          end else begin
            skip_next = eff_hop - fill_inc;
            rs_next   = rs + PW'(fill_inc);
            fill_next = '0;
          end
        end else begin
          fill_next = fill_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      rs   <= '0;
      skip <= '0;
    end else begin
      fill <= fill_next;
      rs   <= rs_next;
      skip <= skip_next;
    end
  end

endmodule

// ===== src/ofs_queue.sv =====
// Small descriptor queue between the front and back parts of the splitter.
// Depends on ofs_pkg for its depth.
module ofs_queue #(
  parameter int WIDTH = 22
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head
);

  logic [WIDTH-1:0] slots [ofs_pkg::QUEUE_DEPTH];
  logic [ofs_pkg::QUEUE_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [ofs_pkg::QUEUE_CNT_BITS-1:0] count;

  assign full       = count == ofs_pkg::QUEUE_CNT_BITS'(ofs_pkg::QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + ofs_pkg::QUEUE_PTR_BITS'(1);
      if (pop)  rd_ptr <= rd_ptr + ofs_pkg::QUEUE_PTR_BITS'(1);
      if (push && !pop)      count <= count + ofs_pkg::QUEUE_CNT_BITS'(1);
      else if (pop && !push) count <= count - ofs_pkg::QUEUE_CNT_BITS'(1);
    end
  end

endmodule

// ===== src/ofs_back.sv =====
// Back part of the splitter: holds the sample store and plays out each
// queued frame descriptor as a run of results. Depends on ofs_pkg.
module ofs_back #(
  parameter int MAX_FRAME   = 64,
  parameter int SAMPLE_BITS = 16,
  parameter int CW          = $clog2(MAX_FRAME + 1),
  parameter int AW          = $clog2(MAX_FRAME) + 1,
  parameter int PW          = AW + 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [SAMPLE_BITS-1:0]       wr_data,
  input  logic                         q_valid,
  input  logic [PW+2*CW-1:0]           q_head,
  output logic                         q_pop,
  output logic                         active,
  output logic [PW-1:0]                cur_start,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [SAMPLE_BITS-1:0]       out_sample,
  output logic [ofs_pkg::POS_BITS-1:0] out_pos,
  output logic                         out_last
);

  logic [SAMPLE_BITS-1:0] mem [2**AW];

  logic [CW-1:0] cur_take, cur_total, idx;
  logic          issue, s1_move, idx_last;
  logic [PW-1:0] rd_ptr;

  logic                         s1_valid, s1_zero, s1_last;
  logic [ofs_pkg::POS_BITS-1:0] s1_pos;
  logic [SAMPLE_BITS-1:0]       rd_data;

  assign q_pop    = !active && q_valid;
  assign s1_move  = s1_valid && (!out_valid || out_ready);
  assign issue    = active && (!s1_valid || s1_move);
  assign idx_last = (idx + CW'(1)) == cur_total;
  assign rd_ptr   = cur_start + PW'(idx);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (issue) rd_data <= mem[rd_ptr[AW-1:0]];
  end

  // Frame sequencer and issue stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (q_pop) begin
      active <= 1'b1;
    end else if (issue && idx_last) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      {cur_total, cur_take, cur_start} <= q_head;
      idx <= '0;
    end else if (issue) begin
      idx <= idx + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (issue) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_zero <= idx >= cur_take;
      s1_pos  <= ofs_pkg::POS_BITS'(idx);
      s1_last <= idx_last;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_sample <= s1_zero ? '0 : rd_data;
      out_pos    <= s1_pos;
      out_last   <= s1_last;
    end
  end

endmodule

// ===== src/overlapping_frame_splitter.sv =====
// Top level of the overlapping frame splitter: configuration registers and
// the front, queue and back parts. Depends on ofs_pkg, ofs_front, ofs_queue, ofs_back.
//
// The block cuts a stream of signed samples into frames of frame_length
// samples, starting a new frame every hop samples, and emits each frame as a
// run of results zero-padded to frame_length (or to the next power of two,
// capped at MAX_FRAME, when round_pow2 is set), with tlast on the final one.
// A flush transfer (tuser high) emits whatever is buffered and empties the
// buffer. The output side loads each frame's descriptor and then plays out
// its results, holding them while m_tready is low; the issue of results
// pauses between frames while the next descriptor loads. The input stalls
// when the two-entry frame queue is full, or when a new sample would
// overwrite store entries that a pending frame has yet to read; the store
// holds twice MAX_FRAME samples (rounded up to a power of two), so in steady
// state the frame playout sets the average cost per input sample. Registers
// are to be written only while idle; the block itself does not enforce this.
module overlapping_frame_splitter #(
  parameter int MAX_FRAME   = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // Input stream.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,  // sample_in
  input  logic                               s_tuser,  // command
  // Output stream.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [((SAMPLE_BITS+ofs_pkg::POS_BITS+7)/8)*8-1:0] m_tdata, // sample_out, position
  output logic                               m_tlast,  // frame_last
  // Configuration write port.
  input  logic                               cfg_we,
  input  logic [ofs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ofs_pkg::CFG_BITS-1:0]       cfg_data
);

  localparam int CW  = $clog2(MAX_FRAME + 1);
  localparam int AW  = $clog2(MAX_FRAME) + 1;
  localparam int PW  = AW + 1;
  localparam int QW  = PW + 2 * CW;
  localparam int ODW = ((SAMPLE_BITS + ofs_pkg::POS_BITS + 7) / 8) * 8;

  logic [ofs_pkg::CFG_BITS-1:0] frame_length, hop;
  logic                         round_pow2;

  // Configuration registers; writes to unused indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= ofs_pkg::FRAME_LENGTH_RESET;
      hop          <= ofs_pkg::HOP_RESET;
      round_pow2   <= ofs_pkg::ROUND_POW2_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ofs_pkg::REG_FRAME_LENGTH: frame_length <= cfg_data;
        ofs_pkg::REG_HOP:          hop          <= cfg_data;
        ofs_pkg::REG_ROUND_POW2:   round_pow2   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic                   q_push, q_full, q_pop, q_valid;
  logic [QW-1:0]          q_data, q_head;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [SAMPLE_BITS-1:0] wr_data;
  logic                   back_active;
  logic [PW-1:0]          back_start;
  logic                   pend_valid;
  logic [PW-1:0]          pend_start;

  logic [SAMPLE_BITS-1:0]       out_sample;
  logic [ofs_pkg::POS_BITS-1:0] out_pos;

  // The oldest frame still to be read is the one in the back part, or else
  // the head of the queue; later frames start no earlier.
  assign pend_valid = back_active || q_valid;
  assign pend_start = back_active ? back_start : q_head[PW-1:0];

  ofs_front #(
    .MAX_FRAME  (MAX_FRAME),
    .SAMPLE_BITS(SAMPLE_BITS),
    .CW         (CW),
    .AW         (AW),
    .PW         (PW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (s_tuser),
    .in_sample (s_tdata[SAMPLE_BITS-1:0]),
    .len_cfg   (frame_length),
    .hop_cfg   (hop),
    .pow2_cfg  (round_pow2),
    .pend_valid(pend_valid),
    .pend_start(pend_start),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  ofs_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head      (q_head)
  );

  ofs_back #(
    .MAX_FRAME  (MAX_FRAME),
    .SAMPLE_BITS(SAMPLE_BITS),
    .CW         (CW),
    .AW         (AW),
    .PW         (PW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .active    (back_active),
    .cur_start (back_start),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_sample(out_sample),
    .out_pos   (out_pos),
    .out_last  (m_tlast)
  );

  assign m_tdata = ODW'({out_pos, out_sample});

endmodule
